/* hdl/uks_pkg.sv */
// uks_pkg: shared types and constants for the unique key stack.
// No dependencies; compile first.
`default_nettype none

package uks_pkg;

    localparam int unsigned UKS_DEPTH  = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ENTRIES_W  = 5;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef logic signed [WORD_W-1:0]    t_word;
    typedef logic        [ENTRIES_W-1:0] t_entries;

endpackage

`default_nettype wire

/* hdl/uks_req_if.sv */
// uks_req_if: request channel (op, key, value) with valid/ready.
// Depends on uks_pkg.
`default_nettype none

interface uks_req_if;
    import uks_pkg::*;

    logic  valid;
    logic  ready;
    t_op   op;
    t_word key;
    t_word value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

`default_nettype wire

/* hdl/uks_rsp_if.sv */
// uks_rsp_if: result channel (status, entry, count) with valid/ready.
// Depends on uks_pkg.
`default_nettype none

interface uks_rsp_if;
    import uks_pkg::*;

    logic     valid;
    logic     ready;
    t_status  status;
    t_word    out_key;
    t_word    out_value;
    t_entries entries;
    logic     is_empty;

    modport source (output valid, output status, output out_key, output out_value,
                    output entries, output is_empty, input ready);
    modport sink   (input valid, input status, input out_key, input out_value,
                    input entries, input is_empty, output ready);
endinterface

`default_nettype wire

/* hdl/uks_store.sv */
// uks_store: key and value memories, one write port, one registered read port.
// Depends on uks_pkg.
`default_nettype none

module uks_store #(
    parameter int unsigned STACK_DEPTH = uks_pkg::UKS_DEPTH,
    parameter int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire uks_pkg::t_word      i_wr_key,
    input  wire uks_pkg::t_word      i_wr_value,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output uks_pkg::t_word           o_rd_key,
    output uks_pkg::t_word           o_rd_value
);
    import uks_pkg::*;

    t_word r_key_mem [STACK_DEPTH];
    t_word r_val_mem [STACK_DEPTH];
    t_word r_rd_key;
    t_word r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_val_mem[i_wr_addr] <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
            r_rd_val <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_val;

endmodule

`default_nettype wire

/* hdl/uks_ctrl.sv */
// uks_ctrl: sequencer for push/pop/peek, serial duplicate-key scan with one
// shared comparator, fill counter and result register. Depends on uks_pkg.
`default_nettype none

module uks_ctrl #(
    parameter int unsigned STACK_DEPTH = uks_pkg::UKS_DEPTH,
    parameter int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    parameter int unsigned CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    uks_req_if.sink                i_req,
    uks_rsp_if.source              o_rsp,
    output logic                   o_wr_en,
    output logic [ADDR_W-1:0]      o_wr_addr,
    output uks_pkg::t_word         o_wr_key,
    output uks_pkg::t_word         o_wr_value,
    output logic                   o_rd_en,
    output logic [ADDR_W-1:0]      o_rd_addr,
    input  wire uks_pkg::t_word    i_rd_key,
    input  wire uks_pkg::t_word    i_rd_value
);
    import uks_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH,
        S_READ,
        S_RDATA,
        S_DONE
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    t_word               r_key;
    t_word               r_val;
    logic [CNT_W-1:0]    r_fill;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_pend;
    logic                r_last;
    t_status             r_status;
    t_word               r_okey;
    t_word               r_oval;

    logic                r_o_valid;
    t_status             r_o_status;
    t_word               r_o_key;
    t_word               r_o_val;
    t_entries            r_o_entries;
    logic                r_o_empty;

    logic                accept;
    logic                full;
    logic                hit;
    logic [CNT_W-1:0]    fill_m1;
    logic                out_free;

    assign accept   = i_req.valid && i_req.ready;
    assign full     = (r_fill == CNT_W'(STACK_DEPTH));
    assign fill_m1  = r_fill - 1'b1;
    assign hit      = r_pend && (i_rd_key == r_key);
    assign out_free = !r_o_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);

    // memory requests
    assign o_rd_en    = ((r_state == S_SCAN) && !r_last) || (r_state == S_READ);
    assign o_rd_addr  = (r_state == S_READ) ? fill_m1[ADDR_W-1:0] : r_idx;
    assign o_wr_en    = (r_state == S_PUSH) && !full;
    assign o_wr_addr  = r_fill[ADDR_W-1:0];
    assign o_wr_key   = r_key;
    assign o_wr_value = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_pend    <= 1'b0;
            r_last    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_o_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_req.op;
                        r_key    <= i_req.key;
                        r_val    <= i_req.value;
                        r_status <= ST_OK;
                        r_okey   <= '0;
                        r_oval   <= '0;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_last   <= 1'b0;
                        unique case (i_req.op)
                            OP_PUSH: r_state <= (r_fill == '0) ? S_PUSH : S_SCAN;
                            OP_POP, OP_PEEK: begin
                                if (r_fill == '0) begin
                                    r_status <= ST_UNDER;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    // compare acts on the key read in the cycle before
                    if (hit) begin
                        r_status <= ST_DUP;
                        r_pend   <= 1'b0;
                        r_state  <= S_DONE;
                    end else if (r_pend && r_last) begin
                        r_pend  <= 1'b0;
                        r_state <= S_PUSH;
                    end else if (!r_last) begin
                        r_pend <= 1'b1;
                        r_last <= (CNT_W'(r_idx) == fill_m1);
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (full) begin
                        r_status <= ST_OVER;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_okey <= i_rd_key;
                    r_oval <= i_rd_value;
                    if (r_op == OP_POP) begin
                        r_fill <= fill_m1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_key     <= r_okey;
                        r_o_val     <= r_oval;
                        r_o_entries <= ENTRIES_W'(r_fill);
                        r_o_empty   <= (r_fill == '0);
                        r_state     <= S_IDLE;
                    end else begin
                        r_o_valid   <= r_o_valid;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.out_key   = r_o_key;
    assign o_rsp.out_value = r_o_val;
    assign o_rsp.entries   = r_o_entries;
    assign o_rsp.is_empty  = r_o_empty;

endmodule

`default_nettype wire

/* hdl/unique_key_stack_core.sv */
// unique_key_stack_core: bounded LIFO of key/value pairs with duplicate-key
// rejection on push. Depends on uks_pkg, uks_req_if, uks_rsp_if, uks_ctrl, uks_store.
//
//   channel   dir   fields                                         handshake
//   i_req     in    op, key, value                                 valid/ready
//   o_rsp     out   status, out_key, out_value, entries, is_empty  valid/ready
//
// Push with n > 0 entries held: one read and one compare per stored key through
// the single read port and comparator, then commit and result register; a
// duplicate ends the scan early. Push onto an empty stack goes straight to commit;
// pop and peek read the top entry; underflow and no-op go to the result register.
// One request at a time; i_req.ready is high only while idle, from the cycle after
// the result register loads. A finished result waits in the output register, so the
// next request is taken while o_rsp stalls.
// i_rst_n (synchronous, active low) empties the stack; memories are not cleared.
`default_nettype none

module unique_key_stack_core #(
    parameter int unsigned STACK_DEPTH = uks_pkg::UKS_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    uks_req_if.sink    i_req,
    uks_rsp_if.source  o_rsp
);
    import uks_pkg::*;

    localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_word             wr_key;
    t_word             wr_value;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_word             rd_key;
    t_word             rd_value;

    uks_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_key   (wr_key),
        .o_wr_value (wr_value),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_key   (rd_key),
        .i_rd_value (rd_value)
    );

    uks_store #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_value (wr_value),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value)
    );

endmodule

`default_nettype wire
